@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the head temperature guard RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define HTG_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("htg assertion failed");

// next-cycle implication, disabled in reset
`define HTG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("htg assertion failed");

`endif

@@ rtl/core/htg_pkg.sv @@
// Package for the head temperature guard: types, constants, dwell table.
// Depends on nothing.
`default_nettype none

package htg_pkg;

  localparam int AdcW   = 12;
  localparam int DwellW = 9;
  localparam int CfgIdxW = 2;

  localparam logic [AdcW-1:0]   AdcMax      = 12'd4095;
  localparam logic [AdcW-1:0]   LimitRst    = 12'd3240;
  localparam logic [AdcW-1:0]   ResumeRst   = 12'd2862;
  localparam logic [AdcW-1:0]   ColdRst     = 12'd1638;
  localparam logic [DwellW-1:0] DwellFull   = 9'd320;
  localparam logic [DwellW-1:0] DwellMin    = 9'd160;

  typedef logic [AdcW-1:0] adc_t;

  typedef enum logic [CfgIdxW-1:0] {
    RegLimit   = 2'd0,
    RegResume  = 2'd1,
    RegCold    = 2'd2,
    RegHotHigh = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    adc_t limit_level;
    adc_t resume_level;
    adc_t cold_level;
    logic hotter_reads_higher;
  } cfg_t;

  typedef struct packed {
    adc_t sample_first;
    adc_t sample_second;
    adc_t sample_third;
  } in_item_t;

  typedef struct packed {
    adc_t              hot_reading;
    adc_t              pin_reading;
    logic              print_allowed;
    logic [DwellW-1:0] dwell_scale;
  } out_item_t;

  typedef struct packed {
    adc_t pin;
    adc_t hot;
  } reading_t;

  function automatic logic [DwellW-1:0] dwell_lookup(input logic [4:0] idx);
    logic [DwellW-1:0] d;
    unique case (idx)
      5'd13:   d = 9'd313;
      5'd14:   d = 9'd302;
      5'd15:   d = 9'd292;
      5'd16:   d = 9'd281;
      5'd17:   d = 9'd270;
      5'd18:   d = 9'd259;
      5'd19:   d = 9'd247;
      5'd20:   d = 9'd235;
      5'd21:   d = 9'd222;
      5'd22:   d = 9'd208;
      5'd23:   d = 9'd192;
      5'd24:   d = 9'd175;
      5'd25, 5'd26, 5'd27, 5'd28, 5'd29, 5'd30, 5'd31: d = DwellMin;
      default: d = DwellFull;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/htg_in_if.sv @@
// Input channel interface: three ADC samples per transaction.
// Depends on htg_pkg.
`default_nettype none

interface htg_in_if;
  import htg_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/htg_out_if.sv @@
// Result channel interface: reading, pin reading, print flag, dwell scale.
// Depends on htg_pkg.
`default_nettype none

interface htg_out_if;
  import htg_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/htg_cfg_if.sv @@
// Configuration write channel interface: register index and write data.
// Depends on htg_pkg.
`default_nettype none

interface htg_cfg_if;
  import htg_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  adc_t                wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

@@ rtl/core/htg_cfg_regs.sv @@
// Configuration register file of the head temperature guard.
// Depends on htg_pkg and htg_cfg_if.
`default_nettype none

module htg_cfg_regs (
  input  wire logic   clk,
  input  wire logic   rst_n,
  htg_cfg_if.sink     cfg_if,
  output htg_pkg::cfg_t cfg
);
  import htg_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  assign cfg_if.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid) begin
      unique case (cfg_reg_t'(cfg_if.index))
        RegLimit:   cfg_nxt.limit_level         = cfg_if.wdata;
        RegResume:  cfg_nxt.resume_level        = cfg_if.wdata;
        RegCold:    cfg_nxt.cold_level          = cfg_if.wdata;
        RegHotHigh: cfg_nxt.hotter_reads_higher = cfg_if.wdata[0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.limit_level         <= LimitRst;
      cfg_r.resume_level        <= ResumeRst;
      cfg_r.cold_level          <= ColdRst;
      cfg_r.hotter_reads_higher <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/htg_median.sv @@
// Median of three samples and optional inversion to a hotter-is-higher reading.
// Depends on htg_pkg.
`default_nettype none

module htg_median (
  input  wire htg_pkg::in_item_t item,
  input  wire logic              hotter_reads_higher,
  output htg_pkg::reading_t      rd
);
  import htg_pkg::*;

  adc_t lo_ab, hi_ab, mid_hc;

  always_comb begin
    lo_ab  = (item.sample_first < item.sample_second) ? item.sample_first
                                                       : item.sample_second;
    hi_ab  = (item.sample_first < item.sample_second) ? item.sample_second
                                                       : item.sample_first;
    mid_hc = (hi_ab < item.sample_third) ? hi_ab : item.sample_third;
    rd.pin = (lo_ab > mid_hc) ? lo_ab : mid_hc;
    rd.hot = hotter_reads_higher ? rd.pin : (AdcMax - rd.pin);
  end

endmodule

`default_nettype wire

@@ rtl/core/htg_guard.sv @@
// Over-temperature latch with hysteresis, dwell scale and result register.
// Depends on htg_pkg and assert_macros.svh.
`default_nettype none

module htg_guard (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire htg_pkg::cfg_t     cfg,
  input  wire logic              rd_valid,
  input  wire htg_pkg::reading_t rd,
  input  wire logic              out_ready,
  output logic                   take,
  output logic                   out_valid,
  output htg_pkg::out_item_t     out_data
);
  import htg_pkg::*;
  `include "assert_macros.svh"

  logic              latch_r, latch_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r;
  logic [DwellW-1:0] dwell;
  logic              adv;

  assign take      = !out_valid_r || out_ready;
  assign adv       = take && rd_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    if (latch_r) begin
      latch_nxt = !(rd.hot <= cfg.resume_level);
    end else begin
      latch_nxt = (rd.hot >= cfg.limit_level);
    end
    priority if (rd.hot <= cfg.cold_level) begin
      dwell = DwellFull;
    end else if (rd.hot >= cfg.limit_level) begin
      dwell = DwellMin;
    end else begin
      dwell = dwell_lookup(rd.hot[AdcW-1:AdcW-5]);
    end
    out_valid_nxt = take ? rd_valid : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        latch_r <= latch_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.hot_reading   <= rd.hot;
      out_data_r.pin_reading   <= rd.pin;
      out_data_r.print_allowed <= !latch_nxt;
      out_data_r.dwell_scale   <= dwell;
    end
  end

  `HTG_ASSERT_IMPLY(a_flag_tracks_latch, clk, rst_n, out_valid_r,
    out_data_r.print_allowed == !latch_r)
  `HTG_ASSERT_NEXT(a_latch_holds_idle, clk, rst_n, !adv, $stable(latch_r))
  `HTG_ASSERT_IMPLY(a_dwell_range, clk, rst_n, out_valid_r,
    (out_data_r.dwell_scale >= DwellMin) && (out_data_r.dwell_scale <= DwellFull))
  `HTG_ASSERT_IMPLY(a_hot_from_pin, clk, rst_n, out_valid_r,
    (out_data_r.hot_reading == out_data_r.pin_reading) ||
    (out_data_r.hot_reading == ~out_data_r.pin_reading))

endmodule

`default_nettype wire

@@ rtl/core/head_temp_guard_and_dwell_scale_unit.sv @@
// Head temperature guard and dwell scale, top level.
// Registers from input transaction to result valid: input register, then result register.
// Throughput: one transaction per cycle unless the output stalls; single compare/latch pass.
// Reset (synchronous, rst_n low): clears both valid stages and the over-temperature latch,
// and loads the configuration registers with their default levels.
`default_nettype none

module head_temp_guard_and_dwell_scale_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  htg_in_if.sink    in_if,
  htg_out_if.source out_if,
  htg_cfg_if.sink   cfg_if
);
  import htg_pkg::*;

  cfg_t     cfg;
  logic     in_valid_r, in_valid_nxt;
  in_item_t in_data_r;
  reading_t rd;
  logic     take;

  assign in_if.ready  = !in_valid_r || take;
  assign in_valid_nxt = in_if.ready ? in_if.valid : in_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      in_data_r <= in_if.data;
    end
  end

  htg_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  htg_median u_median (
    .item                (in_data_r),
    .hotter_reads_higher (cfg.hotter_reads_higher),
    .rd                  (rd)
  );

  htg_guard u_guard (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .rd_valid  (in_valid_r),
    .rd        (rd),
    .out_ready (out_if.ready),
    .take      (take),
    .out_valid (out_if.valid),
    .out_data  (out_if.data)
  );

endmodule

`default_nettype wire

@@ dv/htg_result_checker.sv @@
// Result checker for the head temperature guard: predicts each result from the
// input and configuration transactions and compares it with the result channel.
// Depends on htg_pkg and the htg_in_if, htg_out_if and htg_cfg_if interfaces.
module htg_result_checker
  import htg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  htg_in_if         in_mon,
  htg_out_if        out_mon,
  htg_cfg_if        cfg_mon,
  output int        fail_count,
  output int        pending_results,
  output int        results_checked
);

  localparam logic [DwellW-1:0] DwellSteps [32] = '{
    9'd320, 9'd320, 9'd320, 9'd320, 9'd320, 9'd320, 9'd320, 9'd320,
    9'd320, 9'd320, 9'd320, 9'd320, 9'd320, 9'd313, 9'd302, 9'd292,
    9'd281, 9'd270, 9'd259, 9'd247, 9'd235, 9'd222, 9'd208, 9'd192,
    9'd175, 9'd160, 9'd160, 9'd160, 9'd160, 9'd160, 9'd160, 9'd160
  };

  cfg_t      level_cfg;
  logic      over_temp;
  out_item_t expected_readings [$];
  int        mismatches;
  int        checked;

  function automatic out_item_t predict_reading(in_item_t s);
    adc_t      lo;
    adc_t      hi;
    adc_t      pin;
    adc_t      hot;
    out_item_t r;
    lo  = (s.sample_first < s.sample_second) ? s.sample_first : s.sample_second;
    hi  = (s.sample_first < s.sample_second) ? s.sample_second : s.sample_first;
    pin = (s.sample_third < lo) ? lo : ((s.sample_third > hi) ? hi : s.sample_third);
    hot = level_cfg.hotter_reads_higher ? pin : AdcMax - pin;
    if (over_temp) begin
      if (hot <= level_cfg.resume_level) over_temp = 1'b0;
    end else if (hot >= level_cfg.limit_level) begin
      over_temp = 1'b1;
    end
    r.hot_reading   = hot;
    r.pin_reading   = pin;
    r.print_allowed = !over_temp;
    if (hot <= level_cfg.cold_level) r.dwell_scale = DwellFull;
    else if (hot >= level_cfg.limit_level) r.dwell_scale = DwellMin;
    else r.dwell_scale = DwellSteps[hot[AdcW-1:7]];
    return r;
  endfunction

  always @(posedge clk) begin : scoreboard
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      level_cfg.limit_level         = LimitRst;
      level_cfg.resume_level        = ResumeRst;
      level_cfg.cold_level          = ColdRst;
      level_cfg.hotter_reads_higher = 1'b1;
      over_temp                     = 1'b0;
      expected_readings.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_reg_t'(cfg_mon.index))
          RegLimit:   level_cfg.limit_level = cfg_mon.wdata;
          RegResume:  level_cfg.resume_level = cfg_mon.wdata;
          RegCold:    level_cfg.cold_level = cfg_mon.wdata;
          RegHotHigh: level_cfg.hotter_reads_higher = cfg_mon.wdata[0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) expected_readings.push_back(predict_reading(in_mon.data));
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (expected_readings.size() == 0) begin
          $error("unexpected result transaction: hot_reading %0d, pin_reading %0d",
                 got.hot_reading, got.pin_reading);
          mismatches++;
        end else begin
          want = expected_readings.pop_front();
          checked++;
          if (got.hot_reading !== want.hot_reading) begin
            $error("hot_reading mismatch: expected %0d, got %0d",
                   want.hot_reading, got.hot_reading);
            mismatches++;
          end
          if (got.pin_reading !== want.pin_reading) begin
            $error("pin_reading mismatch: expected %0d, got %0d",
                   want.pin_reading, got.pin_reading);
            mismatches++;
          end
          if (got.print_allowed !== want.print_allowed) begin
            $error("print_allowed mismatch: expected %0d, got %0d",
                   want.print_allowed, got.print_allowed);
            mismatches++;
          end
          if (got.dwell_scale !== want.dwell_scale) begin
            $error("dwell_scale mismatch: expected %0d, got %0d",
                   want.dwell_scale, got.dwell_scale);
            mismatches++;
          end
        end
      end
    end
    fail_count      <= mismatches;
    pending_results <= expected_readings.size();
    results_checked <= checked;
  end

endmodule

@@ dv/head_temp_guard_and_dwell_scale_unit_test.sv @@
// Testbench top for the head temperature guard: clock, reset, configuration
// phases, directed and random sample transactions, random stalls, verdict.
// Depends on htg_pkg, the channel interfaces, the unit and htg_result_checker.
module head_temp_guard_and_dwell_scale_unit_test;
  import htg_pkg::*;

  localparam int ItemTarget = 1650;
  localparam int PhaseItems = 130;

  logic clk;
  logic rst_n;
  logic in_no_idle;
  logic out_no_idle;
  cfg_t stim_cfg;
  int   items_sent;
  int   phase_count;
  int   fail_count;
  int   pending_results;
  int   results_checked;

  htg_in_if  in_ch ();
  htg_out_if out_ch ();
  htg_cfg_if cfg_ch ();

  head_temp_guard_and_dwell_scale_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  htg_result_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_mon         (cfg_ch),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .results_checked (results_checked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      stall = out_no_idle ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  task automatic write_reg(cfg_reg_t idx, adc_t value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      RegLimit:   stim_cfg.limit_level = value;
      RegResume:  stim_cfg.resume_level = value;
      RegCold:    stim_cfg.cold_level = value;
      RegHotHigh: stim_cfg.hotter_reads_higher = value[0];
      default: ;
    endcase
  endtask

  task automatic set_levels(adc_t limit, adc_t resume, adc_t cold, logic hot_high);
    write_reg(RegLimit, limit);
    write_reg(RegResume, resume);
    write_reg(RegCold, cold);
    write_reg(RegHotHigh, {11'($urandom), hot_high});
  endtask

  task automatic send_item(in_item_t it);
    int gap;
    gap = in_no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // median lands on the pin value for the requested hot reading
  task automatic send_toward(int hot_target);
    int   t;
    adc_t pin;
    adc_t lo;
    adc_t hi;
    t   = (hot_target < 0) ? 0 : ((hot_target > 4095) ? 4095 : hot_target);
    pin = stim_cfg.hotter_reads_higher ? adc_t'(t) : AdcMax - adc_t'(t);
    lo  = adc_t'($urandom_range(0, pin));
    hi  = adc_t'($urandom_range(pin, 4095));
    case ($urandom_range(0, 5))
      0: send_item(in_item_t'{pin, lo, hi});
      1: send_item(in_item_t'{pin, hi, lo});
      2: send_item(in_item_t'{lo, pin, hi});
      3: send_item(in_item_t'{hi, pin, lo});
      4: send_item(in_item_t'{lo, hi, pin});
      default: send_item(in_item_t'{hi, lo, pin});
    endcase
  endtask

  task automatic quiesce(int extra);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  initial begin : stimulus
    int   lim;
    int   res;
    int   cld;
    int   offset;
    int   n;
    rst_n        = 1'b0;
    in_no_idle   = 1'b0;
    out_no_idle  = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = RegLimit;
    cfg_ch.wdata = '0;
    items_sent   = 0;
    phase_count  = 1;
    stim_cfg.limit_level         = LimitRst;
    stim_cfg.resume_level        = ResumeRst;
    stim_cfg.cold_level          = ColdRst;
    stim_cfg.hotter_reads_higher = 1'b1;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // reset levels: extremes, cold edge, table steps, latch set and clear
    send_item(in_item_t'{12'd0, 12'd0, 12'd0});
    send_item(in_item_t'{12'd4095, 12'd4095, 12'd4095});
    send_item(in_item_t'{12'd4095, 12'd0, 12'd2048});
    send_item(in_item_t'{12'd0, 12'd2048, 12'd4095});
    send_item(in_item_t'{12'd2048, 12'd4095, 12'd0});
    send_item(in_item_t'{12'hAAA, 12'h555, 12'hFFF});
    send_item(in_item_t'{12'd1638, 12'd1638, 12'd1638});
    send_item(in_item_t'{12'd1639, 12'd1639, 12'd1639});
    send_item(in_item_t'{12'd1664, 12'd1700, 12'd0});
    send_item(in_item_t'{12'd3239, 12'd3239, 12'd3239});
    send_item(in_item_t'{12'd3240, 12'd0, 12'd4095});
    send_item(in_item_t'{12'd3000, 12'd3000, 12'd3000});
    send_item(in_item_t'{12'd2863, 12'd2863, 12'd2863});
    send_item(in_item_t'{12'd2862, 12'd2862, 12'd2862});
    send_item(in_item_t'{12'd100, 12'd5, 12'd2000});
    quiesce(4);

    // inverted reading, resume above limit, cold above limit
    phase_count++;
    set_levels(12'd1000, 12'd3000, 12'd4095, 1'b0);
    send_item(in_item_t'{12'd0, 12'd0, 12'd0});
    send_item(in_item_t'{12'd2000, 12'd2000, 12'd2000});
    send_item(in_item_t'{12'd3095, 12'd3095, 12'd3095});
    send_item(in_item_t'{12'd1095, 12'd1095, 12'd1095});
    send_item(in_item_t'{12'd4095, 12'd4095, 12'd4095});
    send_item(in_item_t'{12'd555, 12'd4000, 12'd2222});
    quiesce(4);

    while (items_sent < ItemTarget) begin
      phase_count++;
      case (phase_count % 6)
        0: begin
          cld = $urandom_range(0, 1500);
          res = $urandom_range(cld, 3500);
          lim = $urandom_range(res, 4095);
          set_levels(adc_t'(lim), adc_t'(res), adc_t'(cld), 1'($urandom));
        end
        1: set_levels(adc_t'($urandom), adc_t'($urandom), adc_t'($urandom), 1'($urandom));
        2: set_levels(12'd4095, 12'd0, 12'd0, 1'($urandom));
        3: set_levels(12'd0, 12'd4095, 12'd4095, 1'($urandom));
        4: set_levels(LimitRst, ResumeRst, ColdRst, 1'($urandom));
        default: begin
          lim = $urandom_range(0, 3000);
          res = $urandom_range(lim, 4095);
          set_levels(adc_t'(lim), adc_t'(res), adc_t'($urandom), 1'($urandom));
        end
      endcase
      in_no_idle  = ($urandom_range(0, 3) == 0);
      out_no_idle = ($urandom_range(0, 3) == 0);
      for (n = 0; n < PhaseItems && items_sent < ItemTarget; n++) begin
        offset = int'($urandom_range(0, 8)) - 4;
        case ($urandom_range(0, 9))
          0, 1: send_toward(int'(stim_cfg.limit_level) + offset);
          2, 3: send_toward(int'(stim_cfg.resume_level) + offset);
          4: send_toward(int'(stim_cfg.cold_level) + offset);
          5: send_toward(int'($urandom_range(12, 25)) * 128 + int'($urandom_range(0, 1)) - 1);
          6, 7: send_toward(int'($urandom_range(0, 4095)));
          default: send_item(in_item_t'{adc_t'($urandom), adc_t'($urandom), adc_t'($urandom)});
        endcase
      end
      quiesce(4);
    end

    in_no_idle  = 1'b0;
    out_no_idle = 1'b0;
    quiesce(10);
    $display("Covered %0d sample transactions and %0d checked results over %0d level settings",
             items_sent, results_checked, phase_count);
    if (fail_count == 0 && pending_results == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/htg_pkg.sv
rtl/core/htg_in_if.sv
rtl/core/htg_out_if.sv
rtl/core/htg_cfg_if.sv
rtl/core/htg_cfg_regs.sv
rtl/core/htg_median.sv
rtl/core/htg_guard.sv
rtl/core/head_temp_guard_and_dwell_scale_unit.sv
dv/htg_result_checker.sv
dv/head_temp_guard_and_dwell_scale_unit_test.sv
